@@ design/unr_pkg.sv @@
// ----------------------------------------------------------------------------
// unr_pkg: shared types and constants for the normalise-and-round block
// Configuration register indexes, rounding mode codes and the config bundle.
// ----------------------------------------------------------------------------
package unr_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// register indexes on the config write channel
	localparam logic [CFG_IDX_W-1:0] CFG_PRECISION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROUNDING  = 2'd1;

	localparam logic [6:0] PRECISION_RESET = 7'd64;

	typedef enum logic [2:0] {
		RND_ZERO    = 3'd0,
		RND_AWAY    = 3'd1,
		RND_FLOOR   = 3'd2,
		RND_CEIL    = 3'd3,
		RND_NEAREST = 3'd4
	} rnd_mode_t;

	// live configuration, as seen by the datapath
	typedef struct packed {
		logic [6:0] precision;
		logic [2:0] mode;       // raw code; unused codes round toward zero
	} cfg_t;

endpackage

@@ design/uint_normalize_round.sv @@
// ----------------------------------------------------------------------------
// uint_normalize_round: unsigned integer to float normalise and round
// Normalises a magnitude to a top-aligned mantissa with its bit length as
// exponent, then rounds to the configured precision and mode.
// ----------------------------------------------------------------------------
//
// Channel   Handshake              Payload
// -------   ---------------------  ------------------------------------------
// input     start, busy            magnitude[63:0], negative
// result    done (1-cycle strobe)  mantissa[63:0], exponent[6:0], is_zero,
//                                  sign_out, inexact
// config    cfg_valid, cfg_ready   cfg_index[1:0], cfg_data[6:0]
//
// One item per cycle; busy is never raised. Path: input register, then
// leading-zero normaliser, rounding and the add of the rounding unit in one
// combinational pass into the result register. That pass (shift tree plus
// WORD_BITS-wide add) sets the clock.
// Reset clears the pipeline valid bits; config comes up as precision 64,
// nearest-even. The receiver cannot stall, so results are never held.
// Config is taken every cycle (cfg_ready tied high); write it only when idle.
//
module uint_normalize_round
	import unr_pkg::*;
#(
	parameter int WORD_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input items
	input  logic                  start,
	output logic                  busy,
	input  logic [63:0]           magnitude,
	input  logic                  negative,
	// results
	output logic                  done,
	output logic [63:0]           mantissa,
	output logic [6:0]            exponent,
	output logic                  is_zero,
	output logic                  sign_out,
	output logic                  inexact,
	// configuration
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int EXP_W = $clog2(WORD_BITS+2);

	cfg_t cfg;

	// stage 1: captured item
	logic                 valid_s1;
	logic [WORD_BITS-1:0] mag_s1;
	logic                 neg_s1;

	// combinational datapath
	logic [WORD_BITS-1:0] norm;
	logic [EXP_W-1:0]     len;
	logic                 zero;
	logic [WORD_BITS-1:0] mant_c;
	logic [EXP_W-1:0]     exp_c;
	logic                 inexact_c;

	// stage 2: result register
	logic                 valid_s2;
	logic [WORD_BITS-1:0] mant_s2;
	logic [EXP_W-1:0]     exp_s2;
	logic                 zero_s2;
	logic                 neg_s2;
	logic                 inexact_s2;

	assign busy = 1'b0;

	unr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	// payload only, no reset; bits above the word are dropped here
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mag_s1 <= magnitude[WORD_BITS-1:0];
			neg_s1 <= negative;
		end
	end

	unr_normalize #(.W(WORD_BITS)) u_norm (
		.value (mag_s1),
		.norm  (norm),
		.len   (len),
		.zero  (zero)
	);

	unr_round #(.W(WORD_BITS)) u_round (
		.cfg     (cfg),
		.norm    (norm),
		.len     (len),
		.zero    (zero),
		.neg     (neg_s1),
		.mant    (mant_c),
		.exp     (exp_c),
		.inexact (inexact_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			mant_s2    <= mant_c;
			exp_s2     <= exp_c;
			zero_s2    <= zero;
			neg_s2     <= neg_s1;
			inexact_s2 <= inexact_c;
		end
	end

	assign done     = valid_s2;
	assign mantissa = 64'(mant_s2);
	assign exponent = 7'(exp_s2);
	assign is_zero  = zero_s2;
	assign sign_out = neg_s2;
	assign inexact  = inexact_s2;

`ifndef SYNTH
	// every accepted item raises done after passing the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result strobe missing two cycles after accept");

	// a nonzero result is normalised and has a nonzero exponent
	a_normalised: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !is_zero) |-> (mantissa[WORD_BITS-1] && exponent != 7'd0))
		else $error("nonzero result not top-aligned");

	// zero result carries no mantissa, exponent or inexact flag
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_zero) |-> (mantissa == 64'd0 && exponent == 7'd0 && !inexact))
		else $error("zero result malformed");
`endif

endmodule

@@ design/unr_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// unr_cfg_regs: configuration register file
// Decodes writes on the config channel into precision and rounding mode.
// ----------------------------------------------------------------------------
module unr_cfg_regs
	import unr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.precision <= PRECISION_RESET;
			cfg_q.mode      <= RND_NEAREST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PRECISION: cfg_q.precision <= cfg_data;
				CFG_ROUNDING:  cfg_q.mode      <= cfg_data[2:0];
				default: ;     // unmapped index, write dropped
			endcase
		end
	end

endmodule

@@ design/unr_normalize.sv @@
// ----------------------------------------------------------------------------
// unr_normalize: leading-zero normaliser
// Log-depth shifter: each step shifts by a power of two when that many top
// bits are clear, and the shift steps form the leading-zero count.
// ----------------------------------------------------------------------------
module unr_normalize #(
	parameter int W = 64
) (
	input  logic [W-1:0]               value,
	output logic [W-1:0]               norm,
	output logic [$clog2(W+2)-1:0]     len,
	output logic                       zero
);

	localparam int LZ_W  = $clog2(W);
	localparam int EXP_W = $clog2(W+2);

	logic [LZ_W-1:0] lz;

	always_comb begin
		logic [W-1:0] v;
		v  = value;
		lz = '0;
		for (int k = LZ_W-1; k >= 0; k--) begin
			if ((v >> (W - (1 << k))) == '0) begin
				v     = v << (1 << k);
				lz[k] = 1'b1;
			end
		end
		norm = v;
	end

	assign zero = (value == '0);
	assign len  = EXP_W'(W) - EXP_W'(lz);

endmodule

@@ design/unr_round.sv @@
// ----------------------------------------------------------------------------
// unr_round: mantissa rounding
// Keeps the top precision bits of the normalised word in one of five modes,
// with carry-out renormalisation and the inexact flag.
// ----------------------------------------------------------------------------
module unr_round
	import unr_pkg::*;
#(
	parameter int W = 64
) (
	input  cfg_t                       cfg,
	input  logic [W-1:0]               norm,
	input  logic [$clog2(W+2)-1:0]     len,
	input  logic                       zero,
	input  logic                       neg,
	output logic [W-1:0]               mant,
	output logic [$clog2(W+2)-1:0]     exp,
	output logic                       inexact
);

	localparam int           EXP_W = $clog2(W+2);
	localparam logic [W-1:0] ONES  = {W{1'b1}};
	localparam logic [W-1:0] TOP   = W'(1) << (W-1);

	logic [6:0]   prec;
	logic         need_round;
	logic [W-1:0] lomask, halfbit, unitbit, t;
	logic         lo_nz, half_set, rest_nz, lsb, up;
	logic [W:0]   sum;

	assign prec       = (cfg.precision == '0) ? 7'd1 : cfg.precision;
	assign need_round = 8'(prec) < 8'(len);

	// discarded-bit mask and the half / unit positions next to it
	assign lomask   = ONES >> prec;
	assign halfbit  = lomask & ~(lomask >> 1);
	assign unitbit  = halfbit << 1;
	assign t        = norm & ~lomask;
	assign lo_nz    = |(norm & lomask);
	assign half_set = |(norm & halfbit);
	assign rest_nz  = |(norm & lomask & ~halfbit);
	assign lsb      = |(norm & unitbit);
	assign sum      = {1'b0, t} + {1'b0, unitbit};

	always_comb begin
		case (rnd_mode_t'(cfg.mode))
			RND_AWAY:    up = 1'b1;
			RND_FLOOR:   up = neg;
			RND_CEIL:    up = !neg;
			RND_NEAREST: up = half_set && (rest_nz || lsb);
			default:     up = 1'b0;
		endcase
	end

	always_comb begin
		mant    = norm;
		exp     = len;
		inexact = 1'b0;
		if (zero) begin
			mant = '0;
			exp  = '0;
		end else if (need_round) begin
			inexact = lo_nz;
			mant    = t;
			if (lo_nz && up) begin
				if (sum[W]) begin
					mant = TOP;
					exp  = len + EXP_W'(1);
				end else begin
					mant = sum[W-1:0];
				end
			end
		end
	end

endmodule
